### rtl/core/bffa_pkg.sv
// Shared types and constants for the first-fit block allocation table.
`timescale 1ns / 1ps

package bffa_pkg;

  // Heap geometry (both powers of two)
  localparam int NUM_BLOCKS  = 256;
  localparam int BLOCK_BYTES = 4096;

  localparam int IDX_W  = $clog2(NUM_BLOCKS);
  localparam int CNT_W  = IDX_W + 1;
  localparam int BLK_SH = $clog2(BLOCK_BYTES);
  localparam int NEED_W = 33 - BLK_SH;

  // Field widths
  localparam int ADDR_W = 32;
  localparam int SIZE_W = 32;
  localparam int ACT_W  = 9;
  localparam int STAT_W = 3;
  localparam int ENT_W  = 3;
  localparam int CIDX_W = 1;

  // Table entry flags
  localparam logic [ENT_W-1:0] ENT_NONE  = 3'b000;
  localparam logic [ENT_W-1:0] ENT_FREE  = 3'b001;
  localparam logic [ENT_W-1:0] ENT_FIRST = 3'b010;
  localparam logic [ENT_W-1:0] ENT_NEXT  = 3'b100;

  // Opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Register indexes
  localparam logic [CIDX_W-1:0] REG_HEAP_BASE = 1'b0;
  localparam logic [CIDX_W-1:0] REG_ACTIVE    = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK         = 3'd0,
    STAT_INVALID    = 3'd1,
    STAT_NOSPACE    = 3'd2,
    STAT_MISALIGNED = 3'd3,
    STAT_RANGE      = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SEARCH,
    ST_MARK,
    ST_FREE
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] heap_base;
    logic [ACT_W-1:0]  active_blocks;
  } cfg_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [ENT_W-1:0] wr_data;
  } ram_req_t;

endpackage

### rtl/core/bffa_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
`timescale 1ns / 1ps

module bffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/bffa_ctrl.sv
// Sequencer: table clearing, first-fit search, run marking and free walk.
`timescale 1ns / 1ps

module bffa_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  bffa_pkg::cfg_t                cfg,
  input  logic                          start,
  input  logic                          opcode,
  input  logic signed [bffa_pkg::SIZE_W-1:0] size_bytes,
  input  logic [bffa_pkg::ADDR_W-1:0]   address,
  output logic                          busy,
  output logic                          done,
  output logic [bffa_pkg::ADDR_W-1:0]   result_address,
  output logic [bffa_pkg::STAT_W-1:0]   status,
  output bffa_pkg::ram_req_t            ram_req,
  input  logic [bffa_pkg::ENT_W-1:0]    rd_data
);

  import bffa_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [IDX_W-1:0]  scan_idx;
  logic [CNT_W-1:0]  run;
  logic [IDX_W-1:0]  start_idx;
  logic [NEED_W-1:0] need;
  logic [CNT_W-1:0]  mark_left;
  status_t           status_q;

  logic [SIZE_W-1:0] sz;
  logic              size_bad;
  logic [SIZE_W:0]   need_sum;
  logic [NEED_W-1:0] need_in;
  logic [ADDR_W-1:0] off;
  logic              misal;
  logic              oor;
  logic [IDX_W-1:0]  idx_in;
  logic [CNT_W-1:0]  lim;
  logic              ent_free;
  logic              has_next;
  logic [CNT_W-1:0]  run_inc;
  logic              hit;
  logic              last;
  logic              more;
  logic              at_top;
  logic [IDX_W-1:0]  found_start;
  logic              fin;
  status_t           fin_status;
  logic [ADDR_W-1:0] fin_addr;

  // request decode, straight off the ports
  assign sz       = size_bytes;
  assign size_bad = (sz == '0) || sz[SIZE_W-1];
  assign need_sum = {1'b0, sz} + (SIZE_W+1)'(BLOCK_BYTES - 1);
  assign need_in  = need_sum[SIZE_W:BLK_SH];
  assign off      = address - cfg.heap_base;
  assign misal    = off[BLK_SH-1:0] != '0;
  assign oor      = (off >> BLK_SH) >= ADDR_W'(NUM_BLOCKS);
  assign idx_in   = off[BLK_SH+IDX_W-1:BLK_SH];

  // search limit, clamped to the table depth
  assign lim = (32'(cfg.active_blocks) > 32'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS)
                                                          : CNT_W'(cfg.active_blocks);

  // scan datapath on the entry just read
  assign ent_free    = |(rd_data & ENT_FREE);
  assign has_next    = |(rd_data & ENT_NEXT);
  assign run_inc     = run + 1'b1;
  assign hit         = ent_free && (NEED_W'(run_inc) == need);
  assign last        = (CNT_W'(scan_idx) + 1'b1) == lim;
  assign at_top      = scan_idx == IDX_W'(NUM_BLOCKS - 1);
  assign more        = has_next && !at_top;
  assign found_start = (run == '0) ? scan_idx : start_idx;

  assign busy = state != ST_IDLE;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (at_top) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          if (opcode == OP_ALLOC) begin
            if (!size_bad && lim != '0) state_next = ST_SEARCH;
          end else begin
            if (!misal && !oor) state_next = ST_FREE;
          end
        end
      end
      ST_SEARCH: begin
        if (hit) state_next = ST_MARK;
        else if (last) state_next = ST_IDLE;
      end
      ST_MARK: begin
        if (mark_left == CNT_W'(1)) state_next = ST_IDLE;
      end
      ST_FREE: begin
        if (!more) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // memory requests and finishing result
  always_comb begin
    ram_req    = '0;
    fin        = 1'b0;
    fin_status = STAT_OK;
    fin_addr   = '0;
    case (state)
      ST_CLEAR: begin
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = scan_idx;
        ram_req.wr_data = ENT_FREE;
      end
      ST_IDLE: begin
        if (start) begin
          if (opcode == OP_ALLOC) begin
            if (size_bad) begin
              fin        = 1'b1;
              fin_status = STAT_INVALID;
            end else if (lim == '0) begin
              fin        = 1'b1;
              fin_status = STAT_NOSPACE;
            end else begin
              ram_req.rd_en   = 1'b1;
              ram_req.rd_addr = '0;
            end
          end else begin
            if (misal) begin
              fin        = 1'b1;
              fin_status = STAT_MISALIGNED;
            end else if (oor) begin
              fin        = 1'b1;
              fin_status = STAT_RANGE;
            end else begin
              ram_req.rd_en   = 1'b1;
              ram_req.rd_addr = idx_in;
            end
          end
        end
      end
      ST_SEARCH: begin
        if (!hit) begin
          if (last) begin
            fin        = 1'b1;
            fin_status = STAT_NOSPACE;
          end else begin
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = scan_idx + 1'b1;
          end
        end
      end
      ST_MARK: begin
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = scan_idx;
        ram_req.wr_data = ((scan_idx == start_idx) ? ENT_FIRST : ENT_NONE)
                        | ((mark_left > CNT_W'(1)) ? ENT_NEXT : ENT_NONE);
        if (mark_left == CNT_W'(1)) begin
          fin        = 1'b1;
          fin_status = STAT_OK;
          fin_addr   = cfg.heap_base + (ADDR_W'(start_idx) << BLK_SH);
        end
      end
      ST_FREE: begin
        // write this entry and read the following one: never the same address
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = scan_idx;
        ram_req.wr_data = ENT_FREE;
        if (more) begin
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = scan_idx + 1'b1;
        end else begin
          fin        = 1'b1;
          fin_status = STAT_OK;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      scan_idx <= '0;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= fin;
      case (state)
        ST_CLEAR: scan_idx <= scan_idx + 1'b1;
        ST_IDLE: begin
          if (start) scan_idx <= (opcode == OP_ALLOC) ? '0 : idx_in;
        end
        ST_SEARCH: scan_idx <= hit ? found_start : scan_idx + 1'b1;
        ST_MARK:   scan_idx <= scan_idx + 1'b1;
        ST_FREE:   scan_idx <= scan_idx + 1'b1;
        default:   scan_idx <= scan_idx;
      endcase
    end
  end

  // run tracking and result payload
  always_ff @(posedge clk) begin
    if (fin) begin
      result_address <= fin_addr;
      status_q       <= fin_status;
    end
    case (state)
      ST_IDLE: begin
        run  <= '0;
        need <= need_in;
      end
      ST_SEARCH: begin
        if (ent_free) begin
          run       <= run_inc;
          start_idx <= found_start;
        end else begin
          run <= '0;
        end
        if (hit) mark_left <= CNT_W'(need);
      end
      ST_MARK: mark_left <= mark_left - 1'b1;
      default: ;
    endcase
  end

  assign status = status_q;

  // searching never writes the table
  a_search_no_write: assert property (@(posedge clk) disable iff (rst)
    state == ST_SEARCH |-> !ram_req.wr_en)
    else $error("table written during search");

  // read and write ports never address the same entry together
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (ram_req.rd_en && ram_req.wr_en) |-> ram_req.rd_addr != ram_req.wr_addr)
    else $error("read and write of the same entry in one cycle");

  // a failed transaction returns address zero, as does a free; only the failing case is asserted
  a_zero_addr: assert property (@(posedge clk) disable iff (rst)
    (done && status != STAT_OK) |-> result_address == '0)
    else $error("non-zero address with failing status");

  // leaving a working state always delivers a result
  a_work_ends_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && $past(state == ST_SEARCH || state == ST_MARK ||
                               state == ST_FREE)) |-> done)
    else $error("transaction finished without a result");

endmodule

### rtl/core/block_table_first_fit_allocator.sv
// Top level: configuration registers, block table RAM and sequencer.
//
//  channel  | handshake                      | payload
//  ---------+--------------------------------+----------------------------------
//  request  | start in, busy out             | opcode, size_bytes, address
//  result   | done out (one-cycle strobe)    | result_address, status
//  config   | cfg_valid in, cfg_ready out    | cfg_index, cfg_data
//
// After reset every table entry is cleared to free (busy high); config
// writes are still taken.
// Allocate: the request is accepted, then table entries are scanned up to
// the end of the first fitting run (at most the active block count), then
// each block of the run is marked. Free: the request is accepted, then each
// entry in the has-next chain is freed. Requests rejected at decode give
// their result in the cycle after acceptance. The single table RAM port
// pair paces these steps. The receiver cannot stall results.
`timescale 1ns / 1ps

module block_table_first_fit_allocator (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                opcode,
  input  logic signed [bffa_pkg::SIZE_W-1:0]  size_bytes,
  input  logic [bffa_pkg::ADDR_W-1:0]         address,
  output logic                                done,
  output logic [bffa_pkg::ADDR_W-1:0]         result_address,
  output logic [bffa_pkg::STAT_W-1:0]         status,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bffa_pkg::CIDX_W-1:0]         cfg_index,
  input  logic [bffa_pkg::ADDR_W-1:0]         cfg_data
);

  import bffa_pkg::*;

  cfg_t             cfg;
  ram_req_t         ram_req;
  logic [ENT_W-1:0] rd_data;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.heap_base     <= '0;
      cfg.active_blocks <= ACT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HEAP_BASE: cfg.heap_base     <= cfg_data;
        REG_ACTIVE:    cfg.active_blocks <= cfg_data[ACT_W-1:0];
        default: ;
      endcase
    end
  end

  // block table
  bffa_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_BLOCKS)
  ) u_table (
    .clk     (clk),
    .rd_en   (ram_req.rd_en),
    .rd_addr (ram_req.rd_addr),
    .rd_data (rd_data),
    .wr_en   (ram_req.wr_en),
    .wr_addr (ram_req.wr_addr),
    .wr_data (ram_req.wr_data)
  );

  // sequencer
  bffa_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .start          (start),
    .opcode         (opcode),
    .size_bytes     (size_bytes),
    .address        (address),
    .busy           (busy),
    .done           (done),
    .result_address (result_address),
    .status         (status),
    .ram_req        (ram_req),
    .rd_data        (rd_data)
  );

endmodule
